FILE: rtl/core/usp_pkg.sv
`timescale 1ns / 1ps

package usp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CAPACITY_RESET = 8'd32;

  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_BAD_LEAD = 3'd1;
  localparam logic [2:0] CAUSE_CONTROL  = 3'd2;
  localparam logic [2:0] CAUSE_NO_ROOM  = 3'd3;
  localparam logic [2:0] CAUSE_BAD_CONT = 3'd4;
  localparam logic [2:0] CAUSE_RANGE    = 3'd5;

  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DEL_CHAR   = 8'h7f;
  localparam logic [7:0] LEAD_E0    = 8'he0;
  localparam logic [7:0] LEAD_ED    = 8'hed;
  localparam logic [7:0] LEAD_F0    = 8'hf0;
  localparam logic [7:0] LEAD_F4    = 8'hf4;
  localparam logic [7:0] SECOND_A0  = 8'ha0;
  localparam logic [7:0] SECOND_90  = 8'h90;

  // One queue entry: a whole character (one to four bytes) or the terminator.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [7:0]      len0;
    logic            done;
    logic [2:0]      cause;
  } usp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } usp_qstat_t;

  // Character length from the lead byte; zero for a byte that cannot lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b inside {[8'h00:8'h7f]}) begin
      n = 3'd1;
    end else if (b inside {[8'hc2:8'hdf]}) begin
      n = 3'd2;
    end else if (b inside {[8'he0:8'hef]}) begin
      n = 3'd3;
    end else if (b inside {[8'hf0:8'hf4]}) begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/usp_front.sv
`timescale 1ns / 1ps

module usp_front import usp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] capacity,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  usp_qstat_t qstat,
  output logic       push,
  output usp_entry_t push_entry
);

  logic [7:0] used_count, used_count_next;
  logic [7:0] pending [3];
  logic [7:0] pending_next [3];
  logic [2:0] expected_len, expected_len_next;
  logic [1:0] received_len, received_len_next;
  logic       stopped, stopped_next;
  logic [2:0] cause_reg, cause_reg_next;

  logic       accept;
  logic [2:0] n_lead;
  logic [8:0] room_sum;
  logic       is_ctrl;
  logic       is_cont;
  logic       more_needed;
  logic       bad_range;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  assign n_lead      = lead_len(in_byte);
  assign room_sum    = {1'b0, used_count} + {6'b0, n_lead};
  assign is_ctrl     = (in_byte < SPACE_CHAR) || (in_byte == DEL_CHAR);
  assign is_cont     = (in_byte & CONT_MASK) == CONT_MARK;
  assign more_needed = ({1'b0, received_len} + 3'd1) < expected_len;

  // The second byte is already held when a three- or four-byte character closes.
  assign bad_range =
      ((expected_len == 3'd3) &&
       (((pending[0] == LEAD_E0) && (pending[1] < SECOND_A0)) ||
        ((pending[0] == LEAD_ED) && (pending[1] >= SECOND_A0)))) ||
      ((expected_len == 3'd4) &&
       (((pending[0] == LEAD_F0) && (pending[1] < SECOND_90)) ||
        ((pending[0] == LEAD_F4) && (pending[1] >= SECOND_90))));

  always_comb begin
    used_count_next   = used_count;
    expected_len_next = expected_len;
    received_len_next = received_len;
    stopped_next      = stopped;
    cause_reg_next    = cause_reg;
    for (int i = 0; i < 3; i++) begin
      pending_next[i] = pending[i];
    end
    push                = 1'b0;
    push_entry.bytes    = '0;
    push_entry.last_idx = 2'd0;
    push_entry.len0     = used_count + 8'd1;
    push_entry.done     = 1'b0;
    push_entry.cause    = CAUSE_NONE;

    if (accept) begin
      if (in_byte == 8'd0) begin
        push            = 1'b1;
        push_entry.len0 = used_count;
        push_entry.done = 1'b1;
        if (stopped) begin
          push_entry.cause = cause_reg;
        end else if (expected_len != 3'd0) begin
          push_entry.cause = CAUSE_BAD_CONT;
        end
        used_count_next   = 8'd0;
        expected_len_next = 3'd0;
        received_len_next = 2'd0;
        stopped_next      = 1'b0;
        cause_reg_next    = CAUSE_NONE;
      end else if (!stopped) begin
        if (expected_len == 3'd0) begin
          if (n_lead == 3'd0) begin
            stopped_next   = 1'b1;
            cause_reg_next = CAUSE_BAD_LEAD;
          end else if (is_ctrl) begin
            stopped_next   = 1'b1;
            cause_reg_next = CAUSE_CONTROL;
          end else if (room_sum >= {1'b0, capacity}) begin
            stopped_next   = 1'b1;
            cause_reg_next = CAUSE_NO_ROOM;
          end else if (n_lead == 3'd1) begin
            push                = 1'b1;
            push_entry.bytes[0] = in_byte;
            used_count_next     = used_count + 8'd1;
          end else begin
            pending_next[0]   = in_byte;
            expected_len_next = n_lead;
            received_len_next = 2'd1;
          end
        end else begin
          if (!is_cont) begin
            stopped_next      = 1'b1;
            cause_reg_next    = CAUSE_BAD_CONT;
            expected_len_next = 3'd0;
            received_len_next = 2'd0;
          end else if (more_needed) begin
            pending_next[received_len] = in_byte;
            received_len_next          = received_len + 2'd1;
          end else if (bad_range) begin
            stopped_next      = 1'b1;
            cause_reg_next    = CAUSE_RANGE;
            expected_len_next = 3'd0;
            received_len_next = 2'd0;
          end else begin
            push = 1'b1;
            for (int i = 0; i < 3; i++) begin
              push_entry.bytes[i] = (2'(i) == received_len) ? in_byte : pending[i];
            end
            push_entry.bytes[3] = in_byte;
            push_entry.last_idx = received_len;
            used_count_next     = used_count + {5'b0, expected_len};
            expected_len_next   = 3'd0;
            received_len_next   = 2'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count   <= 8'd0;
      expected_len <= 3'd0;
      received_len <= 2'd0;
      stopped      <= 1'b0;
      cause_reg    <= CAUSE_NONE;
    end else begin
      used_count   <= used_count_next;
      expected_len <= expected_len_next;
      received_len <= received_len_next;
      stopped      <= stopped_next;
      cause_reg    <= cause_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pending[i] <= pending_next[i];
    end
  end

  // A stop always closes the open character.
  a_stop_closes_char: assert property (@(posedge clk) disable iff (rst)
    stopped |-> (expected_len == 3'd0) && (received_len == 2'd0))
    else $error("character still open while stopped");

endmodule

FILE: rtl/core/usp_queue.sv
`timescale 1ns / 1ps

module usp_queue import usp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  usp_entry_t push_entry,
  input  logic       pop,
  output usp_entry_t head,
  output usp_qstat_t qstat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  usp_entry_t      store [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign head        = store[rd_ptr];
  assign qstat.full  = (count == CW'(DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("entry pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop)
    else $error("entry popped from an empty queue");

endmodule

FILE: rtl/core/usp_back.sv
`timescale 1ns / 1ps

module usp_back import usp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  usp_entry_t  head,
  input  usp_qstat_t  qstat,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  logic [1:0] idx;
  logic [7:0] out_byte;
  logic [7:0] out_len;
  logic [2:0] out_cause;
  logic       out_last;
  logic       out_done;
  logic       load;
  logic       at_last;

  assign load    = !qstat.empty && (!m_tvalid || m_tready);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  assign m_tdata = {5'b0, out_cause, out_len, out_byte};
  assign m_tlast = out_last;
  assign m_tuser = out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= at_last ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= head.bytes[idx];
      out_len   <= head.len0 + {6'b0, idx};
      out_cause <= head.cause;
      out_last  <= at_last;
      out_done  <= head.done;
    end
  end

  // A character being sent keeps its entry at the head of the queue.
  a_entry_held: assert property (@(posedge clk) disable iff (rst)
    (idx != 2'd0) |-> !qstat.empty)
    else $error("character split across queue entries");

  a_done_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast && (m_tdata[7:0] == 8'd0))
    else $error("terminator word malformed");

endmodule

FILE: rtl/core/utf8_safe_prefix_copier.sv
`timescale 1ns / 1ps

// UTF-8 safe prefix copier. String bytes arrive one word per cycle on the
// slave stream and a zero byte ends the string. The front section validates
// each byte as it is accepted and, once a character is complete, places the
// whole character in a small queue (QDEPTH entries); the back section sends the
// queued bytes one word per cycle through a registered output while the sink
// is ready, with tlast on the final byte of each character and tuser on the
// terminator word. Input is accepted every cycle while the queue has room, so
// the sustained rate is one byte per cycle in and at most one word per cycle
// out; a character enters the queue when its last input byte is accepted. The
// capacity register is written through the cfg channel, which is always ready,
// and should only change between strings.
module utf8_safe_prefix_copier import usp_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH  // queue entries, 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // in_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // out_byte[7:0], length[15:8], stop_cause[18:16]
  output logic        m_tlast,    // char_last
  output logic        m_tuser     // text_done
);

  logic [7:0] capacity;
  logic       push;
  logic       pop;
  usp_entry_t push_entry;
  usp_entry_t head;
  usp_qstat_t qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  usp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .capacity   (capacity),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  usp_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  usp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: bench/tb_utf8_safe_prefix_copier.sv
`timescale 1ns / 1ps

module tb_utf8_safe_prefix_copier;
  import usp_pkg::*;

  typedef struct {
    logic [7:0] out_byte;
    logic       char_last;
    logic       text_done;
    logic [7:0] length;
    logic [2:0] stop_cause;
  } copy_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // in_byte[7:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // out_byte[7:0], length[15:8], stop_cause[18:16]
  logic        m_tlast;          // char_last
  logic        m_tuser;          // text_done

  utf8_safe_prefix_copier uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bytes waiting to be sent and the output words they are predicted to cause.
  logic [7:0] text_q[$];
  copy_word_t copy_q[$];

  int mismatches = 0;
  int bytes_queued = 0;
  int bytes_accepted = 0;
  int words_checked = 0;
  int strings_sent = 0;
  int stop_hits[6];
  int src_gap = 0;
  int sink_stall = 0;
  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;

  // Predictor state.
  logic [7:0] cap_model = CAPACITY_RESET;
  logic [7:0] used_cnt = 8'd0;
  logic [7:0] held[3];
  logic [2:0] want_len = 3'd0;
  logic [1:0] got_len = 2'd0;
  logic       halted = 1'b0;
  logic [2:0] halt_cause = CAUSE_NONE;

  function automatic logic [2:0] char_width(input logic [7:0] b);
    if (b <= 8'h7f) return 3'd1;
    if (b >= 8'hc2 && b <= 8'hdf) return 3'd2;
    if (b >= 8'he0 && b <= 8'hef) return 3'd3;
    if (b >= 8'hf0 && b <= 8'hf4) return 3'd4;
    return 3'd0;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic last, input logic done,
                           input logic [7:0] len, input logic [2:0] cause);
    copy_word_t w;
    w.out_byte = b;
    w.char_last = last;
    w.text_done = done;
    w.length = len;
    w.stop_cause = cause;
    copy_q.push_back(w);
  endtask

  task automatic halt_copy(input logic [2:0] cause);
    halted = 1'b1;
    halt_cause = cause;
    want_len = 3'd0;
    got_len = 2'd0;
    stop_hits[cause]++;
  endtask

  task automatic predict_text_byte(input logic [7:0] b);
    logic [2:0] n;
    logic [7:0] seq[4];
    logic [2:0] cause;
    logic       bad;
    int         total;
    if (b == 8'd0) begin
      cause = halted ? halt_cause : (want_len != 0 ? CAUSE_BAD_CONT : CAUSE_NONE);
      if (!halted && want_len != 0) stop_hits[CAUSE_BAD_CONT]++;
      push_word(8'd0, 1'b1, 1'b1, used_cnt, cause);
      used_cnt = 8'd0;
      want_len = 3'd0;
      got_len = 2'd0;
      halted = 1'b0;
      halt_cause = CAUSE_NONE;
    end else if (halted) begin
      // Everything up to the terminator is dropped after a stop.
    end else if (want_len == 0) begin
      n = char_width(b);
      if (n == 0) begin
        halt_copy(CAUSE_BAD_LEAD);
      end else if (b < SPACE_CHAR || b == DEL_CHAR) begin
        halt_copy(CAUSE_CONTROL);
      end else if (int'(used_cnt) + int'(n) >= int'(cap_model)) begin
        halt_copy(CAUSE_NO_ROOM);
      end else if (n == 1) begin
        used_cnt++;
        push_word(b, 1'b1, 1'b0, used_cnt, CAUSE_NONE);
      end else begin
        held[0] = b;
        want_len = n;
        got_len = 2'd1;
      end
    end else if ((b & CONT_MASK) != CONT_MARK) begin
      halt_copy(CAUSE_BAD_CONT);
    end else begin
      total = int'(got_len) + 1;
      if (total < int'(want_len)) begin
        held[got_len] = b;
        got_len = 2'(total);
      end else begin
        for (int i = 0; i < int'(got_len); i++) seq[i] = held[i];
        seq[got_len] = b;
        // Overlong forms, surrogates and values past U+10FFFF show in the second byte.
        bad = (want_len == 3 && ((seq[0] == LEAD_E0 && seq[1] < SECOND_A0) ||
                                 (seq[0] == LEAD_ED && seq[1] >= SECOND_A0))) ||
              (want_len == 4 && ((seq[0] == LEAD_F0 && seq[1] < SECOND_90) ||
                                 (seq[0] == LEAD_F4 && seq[1] >= SECOND_90)));
        if (bad) begin
          halt_copy(CAUSE_RANGE);
        end else begin
          for (int i = 0; i < total; i++) begin
            used_cnt++;
            push_word(seq[i], i == total - 1, 1'b0, used_cnt, CAUSE_NONE);
          end
          want_len = 3'd0;
          got_len = 2'd0;
        end
      end
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_text_byte(s_tdata);
        bytes_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (text_q.size() != 0) begin
          s_tdata <= text_q.pop_front();
          s_tvalid <= 1'b1;
          src_gap = pick_gap(src_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_word();
    copy_word_t want;
    if (copy_q.size() == 0) begin
      $error("unexpected output word: tdata %h tlast %b tuser %b", m_tdata, m_tlast, m_tuser);
      mismatches++;
    end else begin
      want = copy_q.pop_front();
      words_checked++;
      if (m_tdata[7:0] !== want.out_byte) begin
        $error("out_byte: expected %h, actual %h", want.out_byte, m_tdata[7:0]);
        mismatches++;
      end
      if (m_tlast !== want.char_last) begin
        $error("char_last: expected %b, actual %b", want.char_last, m_tlast);
        mismatches++;
      end
      if (m_tuser !== want.text_done) begin
        $error("text_done: expected %b, actual %b", want.text_done, m_tuser);
        mismatches++;
      end
      if (m_tdata[15:8] !== want.length) begin
        $error("length: expected %0d, actual %0d", want.length, m_tdata[15:8]);
        mismatches++;
      end
      if (m_tdata[18:16] !== want.stop_cause) begin
        $error("stop_cause: expected %0d, actual %0d", want.stop_cause, m_tdata[18:16]);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_word();
        sink_stall = pick_gap(sink_calm);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    text_q.push_back(b);
    bytes_queued++;
    if (b == 8'd0) strings_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    return CONT_MARK | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_for(input int w);
    if (w == 2) return 8'($urandom_range(8'hc2, 8'hdf));
    if (w == 3) return 8'($urandom_range(8'he1, 8'hec));
    return 8'($urandom_range(8'hf1, 8'hf3));
  endfunction

  task automatic add_char();
    logic [7:0] lead;
    logic [7:0] second;
    case ($urandom_range(1, 4))
      1: begin
        add_byte(8'($urandom_range(8'h20, 8'h7e)));
      end
      2: begin
        add_byte(8'($urandom_range(8'hc2, 8'hdf)));
        add_byte(cont_byte());
      end
      3: begin
        lead = 8'($urandom_range(8'he0, 8'hef));
        if (lead == LEAD_E0) second = 8'($urandom_range(8'ha0, 8'hbf));
        else if (lead == LEAD_ED) second = 8'($urandom_range(8'h80, 8'h9f));
        else second = cont_byte();
        add_byte(lead);
        add_byte(second);
        add_byte(cont_byte());
      end
      default: begin
        lead = 8'($urandom_range(8'hf0, 8'hf4));
        if (lead == LEAD_F0) second = 8'($urandom_range(8'h90, 8'hbf));
        else if (lead == LEAD_F4) second = 8'($urandom_range(8'h80, 8'h8f));
        else second = cont_byte();
        add_byte(lead);
        add_byte(second);
        add_byte(cont_byte());
        add_byte(cont_byte());
      end
    endcase
  endtask

  // One broken character; cut is set when the string should end right after it.
  task automatic add_fault(output bit cut);
    logic [7:0] b;
    int w;
    cut = 1'b0;
    case ($urandom_range(0, 5))
      0: begin
        if ($urandom_range(0, 1)) add_byte(8'($urandom_range(8'h80, 8'hc1)));
        else add_byte(8'($urandom_range(8'hf5, 8'hff)));
      end
      1: begin
        if ($urandom_range(0, 1)) add_byte(8'($urandom_range(8'h01, 8'h1f)));
        else add_byte(DEL_CHAR);
      end
      2: begin
        w = $urandom_range(2, 4);
        add_byte(lead_for(w));
        repeat ($urandom_range(0, w - 2)) add_byte(cont_byte());
        do b = 8'($urandom_range(1, 255)); while ((b & CONT_MASK) == CONT_MARK);
        add_byte(b);
      end
      3: begin
        case ($urandom_range(0, 3))
          0: begin
            add_byte(LEAD_E0);
            add_byte(8'($urandom_range(8'h80, 8'h9f)));
            add_byte(cont_byte());
          end
          1: begin
            add_byte(LEAD_ED);
            add_byte(8'($urandom_range(8'ha0, 8'hbf)));
            add_byte(cont_byte());
          end
          2: begin
            add_byte(LEAD_F0);
            add_byte(8'($urandom_range(8'h80, 8'h8f)));
            add_byte(cont_byte());
            add_byte(cont_byte());
          end
          default: begin
            add_byte(LEAD_F4);
            add_byte(8'($urandom_range(8'h90, 8'hbf)));
            add_byte(cont_byte());
            add_byte(cont_byte());
          end
        endcase
      end
      4: begin
        w = $urandom_range(2, 4);
        add_byte(lead_for(w));
        repeat ($urandom_range(0, w - 2)) add_byte(cont_byte());
        cut = 1'b1;
      end
      default: begin
        add_byte(8'($urandom_range(1, 255)));
      end
    endcase
  endtask

  task automatic add_string();
    int n;
    bit cut;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
    cut = 1'b0;
    for (int i = 0; i < n && !cut; i++) begin
      if ($urandom_range(0, 99) < 12) add_fault(cut);
      else add_char();
    end
    add_byte(8'd0);
  endtask

  // Returns on a rising edge once every queued byte is in and every word is out, or after a spin limit.
  task automatic wait_idle();
    int spins;
    spins = 0;
    while ((bytes_accepted != bytes_queued || copy_q.size() != 0) && spins < 200000) begin
      @(posedge clk);
      spins++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [7:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_model = v;
  endtask

  initial begin
    logic [7:0] directed[] = '{
      8'h20, 8'h7e, 8'hc2, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h00,
      8'hff, 8'h00,
      8'h7f, 8'h41, 8'h00,
      8'hed, 8'ha0, 8'h80, 8'h00,
      8'he1, 8'h41, 8'h00,
      8'hf0, 8'h90, 8'h00,
      8'h00
    };
    logic [7:0] caps[6];
    int start;

    caps = '{8'd1, 8'd255, 8'd2, 8'd6, 8'd32, 8'($urandom_range(3, 254))};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset capacity: extremes, each fault kind but no room, stop then ignore, cut-off character.
    foreach (directed[i]) add_byte(directed[i]);
    wait_idle();

    foreach (caps[p]) begin
      write_capacity(caps[p]);
      src_calm = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      // The smallest buffer leaves no room for anything but the terminator.
      if (p == 0) begin
        add_byte(8'h41);
        add_byte(8'h00);
      end
      start = bytes_queued;
      while (bytes_queued - start < 8) add_string();
      wait_idle();
    end

    if (copy_q.size() != 0) begin
      $error("%0d expected output words never arrived", copy_q.size());
      mismatches++;
    end
    $display("Ran %0d bytes in %0d strings over %0d capacity settings; %0d words checked.",
             bytes_accepted, strings_sent, $size(caps) + 1, words_checked);
    $display("Stops seen: bad lead %0d, control %0d, no room %0d, bad cont %0d, range %0d.",
             stop_hits[CAUSE_BAD_LEAD], stop_hits[CAUSE_CONTROL], stop_hits[CAUSE_NO_ROOM],
             stop_hits[CAUSE_BAD_CONT], stop_hits[CAUSE_RANGE]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
